[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the RTL; sampled on i_clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Check a condition in the cycle after a trigger.
`define ASSERT_NEXT(label, trig, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (expr)) else $error(msg);

`endif

[hw/rtl/f2dt_pkg.sv]
// ----------------------------------------------------------------------------
// f2dt_pkg
// Types, constants and helpers for the fixed-point to decimal text converter.
// ----------------------------------------------------------------------------
package f2dt_pkg;

    typedef logic [3:0] t_digit;

    localparam int INT_W      = 32;
    localparam int FRAC_W     = 32;
    localparam int INT_DIGITS = 10;
    localparam int PREC_W     = 5;

    localparam logic [PREC_W-1:0] PREC_RESET = 5'd6;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_POINT = 8'h2E;

    localparam logic CFG_PRECISION   = 1'b0;
    localparam logic CFG_FORCE_POINT = 1'b1;

    localparam t_digit DIGIT_NINE = 4'd9;

    // Apply a rounding increment to one decimal digit; a nine wraps to zero.
    function automatic t_digit f_round(input t_digit d, input logic inc);
        t_digit r;
        r = d;
        if (inc) begin
            if (d == DIGIT_NINE) begin
                r = 4'd0;
            end else begin
                r = d + 4'd1;
            end
        end
        return r;
    endfunction

endpackage

[hw/rtl/fixed_to_decimal_text_top.sv]
// ----------------------------------------------------------------------------
// fixed_to_decimal_text_top
// Unsigned Q32.32 magnitude to rounded decimal ASCII text, one char per beat.
// ----------------------------------------------------------------------------
// Each request on the slave stream carries integer_part in tdata[31:0] and
// fraction_part in tdata[63:32]. The block scales by ten to the precision,
// rounds half up and streams the text: integer digits without leading zeros,
// an optional '.', then the fractional digits, with tlast on the final char.
// A request is accepted in the idle state, then converted by a 32-step
// bit-serial binary to BCD shifter, with one fractional digit per cycle from a
// times-ten unit running alongside, and prepared for output. The integer
// positions (10, leading zeros are dropped without output) are then walked in
// turn, followed by the point and the fractional digits; any stall on the
// master side holds the walk. A new request is taken as soon as the last
// character sits in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fixed_to_decimal_text_top #(
    parameter int MAX_PRECISION = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config: index 0 precision, index 1 force_point
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [f2dt_pkg::PREC_W-1:0]   i_cfg_wdata,
    // tdata: integer_part [31:0], fraction_part [63:32]
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [63:0]                   s_axis_tdata,
    // tdata: out_char [7:0]; tlast: last_char
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,
    output logic                          m_axis_tlast
);

    localparam int PW  = $clog2(MAX_PRECISION + 1);
    localparam int FDW = 4 * MAX_PRECISION;
    localparam int BW  = 4 * f2dt_pkg::INT_DIGITS;
    localparam int CW  = $clog2(f2dt_pkg::INT_W);
    localparam int ICW = $clog2(f2dt_pkg::INT_DIGITS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_INT  = 3'd3;
    localparam logic [2:0] S_PT   = 3'd4;
    localparam logic [2:0] S_FRAC = 3'd5;

    logic [2:0]                      r_state, n_state;
    logic [f2dt_pkg::INT_W-1:0]      r_ip, n_ip;
    logic [f2dt_pkg::FRAC_W-1:0]     r_fr, n_fr;
    logic [PW-1:0]                   r_p, n_p;
    logic                            r_fp, n_fp;
    logic [CW-1:0]                   r_cnt, n_cnt;
    logic [BW-1:0]                   r_bcd, n_bcd;
    logic [FDW-1:0]                  r_fd, n_fd;
    logic [MAX_PRECISION-1:0]        r_fnine, n_fnine;
    logic [f2dt_pkg::INT_DIGITS-1:0] r_inine, n_inine;
    logic                            r_icarry, n_icarry;
    logic [ICW-1:0]                  r_icnt, n_icnt;
    logic                            r_started, n_started;
    logic [PW-1:0]                   r_fcnt, n_fcnt;
    logic                            r_ov, n_ov;
    logic [7:0]                      r_ochar, n_ochar;
    logic                            r_olast, n_olast;
    logic [f2dt_pkg::PREC_W-1:0]     r_precision;
    logic                            r_force;

    logic [PW-1:0]                   w_p;
    logic [BW-1:0]                   w_bcd_adj;
    logic [f2dt_pkg::INT_DIGITS-1:0] w_bcd_nine;
    logic [35:0]                     w_prod;
    logic                            w_gen;
    f2dt_pkg::t_digit                w_new_digit;
    logic [FDW+3:0]                  w_fd_in;
    logic [FDW+3:0]                  w_fd_out;
    logic [MAX_PRECISION:0]          w_fn_in;
    logic [MAX_PRECISION:0]          w_fn_ext;
    logic                            w_can_load;
    logic                            w_point;
    f2dt_pkg::t_digit                w_idig;
    logic                            w_ilast;
    logic                            w_emit;
    f2dt_pkg::t_digit                w_fdig;
    logic                            w_flast;

    assign w_p = (r_precision > f2dt_pkg::PREC_W'(MAX_PRECISION)) ?
                 PW'(MAX_PRECISION) : r_precision[PW-1:0];

    always_comb begin
        for (int k = 0; k < f2dt_pkg::INT_DIGITS; k++) begin
            w_bcd_adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ?
                                  r_bcd[4*k +: 4] + 4'd3 : r_bcd[4*k +: 4];
            w_bcd_nine[k]       = (r_bcd[4*k +: 4] == f2dt_pkg::DIGIT_NINE);
        end
    end

    assign w_prod      = {1'b0, r_fr, 3'b000} + {3'b000, r_fr, 1'b0};
    assign w_gen       = (r_cnt < CW'(r_p));
    assign w_new_digit = w_gen ? w_prod[35:32] : 4'd0;
    assign w_fd_in     = {w_new_digit, r_fd};
    assign w_fd_out    = {4'h0, r_fd};
    assign w_fn_in     = {(w_gen ? (w_new_digit == f2dt_pkg::DIGIT_NINE) : 1'b1), r_fnine};
    assign w_fn_ext    = {1'b1, r_fnine};

    assign w_can_load = !r_ov || m_axis_tready;
    assign w_point    = (r_p != PW'(0)) || r_fp;

    assign w_idig  = f2dt_pkg::f_round(r_bcd[BW-1 -: 4],
                                       r_icarry && (&r_inine[f2dt_pkg::INT_DIGITS-2:0]));
    assign w_ilast = (r_icnt == ICW'(f2dt_pkg::INT_DIGITS - 1));
    assign w_emit  = r_started || (w_idig != 4'd0) || w_ilast;

    assign w_fdig  = f2dt_pkg::f_round(r_fd[3:0],
                                       r_fr[f2dt_pkg::FRAC_W-1] && (&w_fn_ext[MAX_PRECISION:1]));
    assign w_flast = ((r_fcnt + PW'(1)) == r_p);

    always_comb begin
        n_state   = r_state;
        n_ip      = r_ip;
        n_fr      = r_fr;
        n_p       = r_p;
        n_fp      = r_fp;
        n_cnt     = r_cnt;
        n_bcd     = r_bcd;
        n_fd      = r_fd;
        n_fnine   = r_fnine;
        n_inine   = r_inine;
        n_icarry  = r_icarry;
        n_icnt    = r_icnt;
        n_started = r_started;
        n_fcnt    = r_fcnt;
        n_ov      = r_ov && !m_axis_tready;
        n_ochar   = r_ochar;
        n_olast   = r_olast;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_ip    = s_axis_tdata[f2dt_pkg::INT_W-1:0];
                    n_fr    = s_axis_tdata[63:f2dt_pkg::INT_W];
                    n_p     = w_p;
                    n_fp    = r_force;
                    n_cnt   = '0;
                    n_bcd   = '0;
                    n_fnine = '1;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd = {w_bcd_adj[BW-2:0], r_ip[f2dt_pkg::INT_W-1]};
                n_ip  = {r_ip[f2dt_pkg::INT_W-2:0], 1'b0};
                if (r_cnt < CW'(MAX_PRECISION)) begin
                    n_fd    = w_fd_in[FDW+3:4];
                    n_fnine = w_fn_in[MAX_PRECISION:1];
                end
                if (w_gen) begin
                    n_fr = w_prod[f2dt_pkg::FRAC_W-1:0];
                end
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(f2dt_pkg::INT_W - 1)) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_inine   = w_bcd_nine;
                n_icarry  = r_fr[f2dt_pkg::FRAC_W-1] && (&r_fnine);
                n_icnt    = '0;
                n_started = 1'b0;
                n_state   = S_INT;
            end
            S_INT: begin
                if (!w_emit || w_can_load) begin
                    if (w_emit) begin
                        n_ov    = 1'b1;
                        n_ochar = f2dt_pkg::CHAR_ZERO + {4'h0, w_idig};
                        n_olast = w_ilast && !w_point;
                    end
                    n_bcd     = {r_bcd[BW-5:0], 4'h0};
                    n_inine   = {r_inine[f2dt_pkg::INT_DIGITS-2:0], 1'b1};
                    n_icnt    = r_icnt + ICW'(1);
                    n_started = r_started || w_emit;
                    if (w_ilast) begin
                        n_state = w_point ? S_PT : S_IDLE;
                    end
                end
            end
            S_PT: begin
                if (w_can_load) begin
                    n_ov    = 1'b1;
                    n_ochar = f2dt_pkg::CHAR_POINT;
                    n_olast = (r_p == PW'(0));
                    n_fcnt  = '0;
                    n_state = (r_p == PW'(0)) ? S_IDLE : S_FRAC;
                end
            end
            S_FRAC: begin
                if (w_can_load) begin
                    n_ov    = 1'b1;
                    n_ochar = f2dt_pkg::CHAR_ZERO + {4'h0, w_fdig};
                    n_olast = w_flast;
                    n_fd    = w_fd_out[FDW+3:4];
                    n_fnine = w_fn_ext[MAX_PRECISION:1];
                    n_fcnt  = r_fcnt + PW'(1);
                    if (w_flast) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ov        <= 1'b0;
            r_precision <= f2dt_pkg::PREC_RESET;
            r_force     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    f2dt_pkg::CFG_PRECISION:   r_precision <= i_cfg_wdata;
                    f2dt_pkg::CFG_FORCE_POINT: r_force     <= i_cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ip      <= n_ip;
        r_fr      <= n_fr;
        r_p       <= n_p;
        r_fp      <= n_fp;
        r_cnt     <= n_cnt;
        r_bcd     <= n_bcd;
        r_fd      <= n_fd;
        r_fnine   <= n_fnine;
        r_inine   <= n_inine;
        r_icarry  <= n_icarry;
        r_icnt    <= n_icnt;
        r_started <= n_started;
        r_fcnt    <= n_fcnt;
        r_ochar   <= n_ochar;
        r_olast   <= n_olast;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_ochar;
    assign m_axis_tlast  = r_olast;

    `ASSERT_NEXT(a_accept_starts, s_axis_tvalid && s_axis_tready, r_state == S_CONV,
                 "accepted request did not start conversion")
    `ASSERT_ALWAYS(a_frac_count, (r_state != S_FRAC) || (r_fcnt < r_p),
                   "fraction digit count past precision")
    `ASSERT_ALWAYS(a_int_done, (r_state != S_PT && r_state != S_FRAC) || r_started,
                   "no integer digit emitted before point")

endmodule

[tb/sv/fixed_to_decimal_text_top_tb.sv]
// ----------------------------------------------------------------------------
// fixed_to_decimal_text_top_tb
// Self-checking bench for the Q32.32 to decimal ASCII text converter.
// ----------------------------------------------------------------------------
// A queue of conversion requests feeds a stream driver; every accepted request
// is turned into its expected characters by an in-bench formatter that uses
// the current precision and force-point settings. A monitor pops and compares
// each output character and its last flag. Directed values cover zero, all
// ones, exact halves, rounding carries into the integer and clamped precision;
// random phases sweep the settings with bursty idling on both streams, one
// long output hold-off and a closing stretch at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_to_decimal_text_top_tb;

    localparam int MAX_PREC = 20;
    localparam int PHASE_ITEMS = 35;
    localparam int NUM_PHASES = 13;
    localparam int LONG_HOLD_CYCLES = 600;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = f2dt_pkg::CFG_PRECISION;
    logic [4:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    logic [63:0] conv_requests[$];
    t_text_char  text_expected[$];

    logic [4:0]  prec_shadow = f2dt_pkg::PREC_RESET;
    logic        point_shadow = 1'b0;

    bit          idle_en = 1'b0;
    bit          long_hold_go = 1'b0;
    logic        sink_block = 1'b0;
    int          src_gap = 0;
    int          sink_gap = 0;
    int          mismatches = 0;

    fixed_to_decimal_text_top #(
        .MAX_PRECISION(MAX_PREC)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),    // integer_part [31:0], fraction_part [63:32]
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),    // out_char [7:0]
        .m_axis_tlast (m_axis_tlast)     // last_char
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void format_decimal(input logic [31:0] int_part,
                                           input logic [31:0] frac_part);
        logic [35:0] acc;
        logic [31:0] rem;
        logic [32:0] whole;
        logic [3:0]  frac_dig[MAX_PREC];
        logic [3:0]  int_dig[11];
        int          n_prec;
        int          i;
        int          n;
        bit          carry;
        t_text_char  c;
        n_prec = (prec_shadow > MAX_PREC) ? MAX_PREC : int'(prec_shadow);
        rem = frac_part;
        for (i = 0; i < n_prec; i++) begin
            acc = {4'd0, rem} * 36'd10;
            frac_dig[i] = acc[35:32];
            rem = acc[31:0];
        end
        whole = {1'b0, int_part};
        if (rem[31]) begin
            carry = 1'b1;
            for (i = n_prec - 1; i >= 0 && carry; i--) begin
                if (frac_dig[i] == 4'd9) begin
                    frac_dig[i] = 4'd0;
                end else begin
                    frac_dig[i] = frac_dig[i] + 4'd1;
                    carry = 1'b0;
                end
            end
            if (carry) begin
                whole = whole + 33'd1;
            end
        end
        n = 0;
        do begin
            int_dig[n] = 4'(whole % 33'd10);
            whole = whole / 33'd10;
            n++;
        end while (whole != 0);
        for (i = n - 1; i >= 0; i--) begin
            c.ch = f2dt_pkg::CHAR_ZERO + {4'd0, int_dig[i]};
            c.last = 1'b0;
            text_expected.push_back(c);
        end
        if (n_prec > 0 || point_shadow) begin
            c.ch = f2dt_pkg::CHAR_POINT;
            c.last = 1'b0;
            text_expected.push_back(c);
        end
        for (i = 0; i < n_prec; i++) begin
            c.ch = f2dt_pkg::CHAR_ZERO + {4'd0, frac_dig[i]};
            c.last = 1'b0;
            text_expected.push_back(c);
        end
        c = text_expected.pop_back();
        c.last = 1'b1;
        text_expected.push_back(c);
    endfunction

    function automatic logic [63:0] rand_request();
        logic [31:0] ip;
        logic [31:0] fp;
        ip = $urandom;
        fp = $urandom;
        case ($urandom_range(0, 5))
            0: begin
            end
            1: begin
                ip = $urandom_range(0, 99);
            end
            2: begin
                ip = ip >> $urandom_range(0, 31);
            end
            3: begin
                fp = fp & ~((32'd1 << $urandom_range(0, 31)) - 32'd1);
                ip = ip >> $urandom_range(0, 31);
            end
            4: begin
                ip = 32'hFFFF_FFFF - $urandom_range(0, 3);
                fp = 32'hFFFF_FFFF - $urandom_range(0, 255);
            end
            default: begin
                ip = $urandom_range(0, 9);
                fp = (fp[0]) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
        endcase
        return {fp, ip};
    endfunction

    task automatic add_request(input logic [31:0] int_part, input logic [31:0] frac_part);
        conv_requests.push_back({frac_part, int_part});
    endtask

    task automatic write_reg(input logic idx, input logic [4:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == f2dt_pkg::CFG_PRECISION) begin
            prec_shadow = val;
        end else begin
            point_shadow = val[0];
        end
        @(negedge i_clk);
    endtask

    task automatic wait_text_drained();
        @(negedge i_clk);
        while (conv_requests.size() != 0 || s_axis_tvalid || text_expected.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // request driver
    always @(posedge i_clk) begin : drive_requests
        logic        nxt_valid;
        logic [63:0] nxt_data;
        nxt_valid = s_axis_tvalid;
        nxt_data = s_axis_tdata;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
            src_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                format_decimal(s_axis_tdata[31:0], s_axis_tdata[63:32]);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (idle_en && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(0, 17);
                end else if (conv_requests.size() != 0) begin
                    nxt_data = conv_requests.pop_front();
                    nxt_valid = 1'b1;
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata <= nxt_data;
    end

    // character monitor
    always @(posedge i_clk) begin : check_text
        t_text_char want;
        logic       nxt_ready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (text_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected char: char %h last %b", m_axis_tdata, m_axis_tlast);
                end
            end else begin
                want = text_expected.pop_front();
                if (m_axis_tdata !== want.ch || m_axis_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("char mismatch: expected char %h last %b, got char %h last %b",
                                 want.ch, want.last, m_axis_tdata, m_axis_tlast);
                    end
                end
            end
        end
        nxt_ready = 1'b1;
        if (!i_rst_n || sink_block) begin
            nxt_ready = 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            nxt_ready = 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            sink_gap = $urandom_range(0, 17);
            nxt_ready = 1'b0;
        end
        m_axis_tready <= nxt_ready;
    end

    // long output hold-off
    initial begin
        wait (long_hold_go);
        @(posedge i_clk);
        sink_block <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
        sink_block <= 1'b0;
    end

    initial begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        logic [4:0] prec;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        add_request(32'd0, 32'd0);
        add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_request(32'd0, 32'h8000_0000);
        add_request(32'd0, 32'hFFFF_FFFF);
        add_request(32'd9, 32'hFFFF_F000);
        add_request(32'd1_000_000_000, 32'd0);
        add_request(32'd12345, 32'h1999_999A);
        wait_text_drained();

        write_reg(f2dt_pkg::CFG_PRECISION, 5'd0);
        write_reg(f2dt_pkg::CFG_FORCE_POINT, 5'd0);
        add_request(32'd0, 32'h8000_0000);
        add_request(32'd0, 32'h7FFF_FFFF);
        add_request(32'hFFFF_FFFF, 32'h8000_0000);
        add_request(32'd7, 32'd0);
        wait_text_drained();

        write_reg(f2dt_pkg::CFG_FORCE_POINT, 5'd1);
        add_request(32'd5, 32'd0);
        add_request(32'd0, 32'hC000_0000);
        wait_text_drained();

        write_reg(f2dt_pkg::CFG_PRECISION, 5'd20);
        write_reg(f2dt_pkg::CFG_FORCE_POINT, 5'd0);
        add_request(32'd0, 32'd1);
        add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_request(32'd3, 32'h243F_6A88);
        wait_text_drained();

        write_reg(f2dt_pkg::CFG_PRECISION, 5'd31);
        write_reg(f2dt_pkg::CFG_FORCE_POINT, 5'd1);
        add_request(32'd0, 32'h5555_5555);
        add_request(32'd1, 32'hFFFF_FFFF);
        add_request(32'd42, 32'h0800_0000);
        wait_text_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: prec = 5'd20;
                1: prec = 5'd0;
                2: prec = 5'd31;
                3: prec = 5'd1;
                5: prec = 5'd20;
                default: prec = 5'($urandom_range(0, 31));
            endcase
            write_reg(f2dt_pkg::CFG_PRECISION, prec);
            write_reg(f2dt_pkg::CFG_FORCE_POINT, 5'($urandom_range(0, 1)));
            idle_en = (ph < NUM_PHASES - 2) && (ph != 5);
            if (ph == 5) begin
                long_hold_go = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                conv_requests.push_back(rand_request());
            end
            wait_text_drained();
        end

        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && text_expected.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/f2dt_pkg.sv
hw/rtl/fixed_to_decimal_text_top.sv
tb/sv/fixed_to_decimal_text_top_tb.sv
